// ===== design/nearest_segment_search_assert.svh =====
`ifndef NEAREST_SEGMENT_SEARCH_ASSERT_SVH
`define NEAREST_SEGMENT_SEARCH_ASSERT_SVH

// same-cycle implication, off during reset
`define NSS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nss assertion failed");

// next-cycle implication, off during reset
`define NSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nss assertion failed");

`endif

// ===== design/nss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nss_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int MUL_W   = 19;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DOT_W   = 35;
  localparam int SQ_W    = 34;
  localparam int CRS_W   = 35;
  localparam int LO_W    = 18;
  localparam int NUM_W   = 70;
  localparam int QUO_W   = 36;
  localparam int ROOT_W  = QUO_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int RAD_W   = 17;
  localparam int DIST_W  = 17;
  localparam int ENT_W   = 6 * COORD_W;
  localparam int MUL_STEPS  = 27;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {
    OP_WRITE,
    OP_SEARCH
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [IDX_W-1:0]           seg_index;
    logic signed [COORD_W-1:0]  p_x;
    logic signed [COORD_W-1:0]  p_y;
    logic signed [COORD_W-1:0]  p_z;
    logic signed [COORD_W-1:0]  e_x;
    logic signed [COORD_W-1:0]  e_y;
    logic signed [COORD_W-1:0]  e_z;
    logic                       excl_en;
    logic [IDX_W-1:0]           excl_idx;
    logic [RAD_W-1:0]           radius;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NEXT,
    BK_FETCH,
    BK_LOAD,
    BK_MUL,
    BK_ACC,
    BK_DEC,
    BK_DIV,
    BK_SQRT,
    BK_CMP,
    BK_DONE
  } bk_state_t;

endpackage
`default_nettype wire

// ===== design/nss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nss_front
  import nss_pkg::*;
(
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_cmd,
  input  wire logic [IDX_W-1:0]           in_seg_index,
  input  wire logic signed [COORD_W-1:0]  in_p_x,
  input  wire logic signed [COORD_W-1:0]  in_p_y,
  input  wire logic signed [COORD_W-1:0]  in_p_z,
  input  wire logic signed [COORD_W-1:0]  in_e_x,
  input  wire logic signed [COORD_W-1:0]  in_e_y,
  input  wire logic signed [COORD_W-1:0]  in_e_z,
  input  wire logic signed [CNT_W-1:0]    in_exclude_index,
  input  wire logic [RAD_W-1:0]           in_scan_radius,
  input  wire q_stat_t                    q_stat,
  output logic                            push,
  output item_t                           push_item
);

  logic in_range;

  always_comb begin
    busy     = q_stat.full;
    in_range = 32'(in_seg_index) < MAX_SEGMENTS;
    // out-of-range writes are dropped here
    push     = start && !q_stat.full && (in_cmd || in_range);
    push_item.op        = in_cmd ? OP_SEARCH : OP_WRITE;
    push_item.seg_index = in_seg_index;
    push_item.p_x       = in_p_x;
    push_item.p_y       = in_p_y;
    push_item.p_z       = in_p_z;
    push_item.e_x       = in_e_x;
    push_item.e_y       = in_e_y;
    push_item.e_z       = in_e_z;
    push_item.excl_en   = !in_exclude_index[CNT_W-1];
    push_item.excl_idx  = in_exclude_index[IDX_W-1:0];
    push_item.radius    = in_scan_radius;
  end

endmodule
`default_nettype wire

// ===== design/nss_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nss_queue
  import nss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output q_stat_t    q_stat
);

  item_t      slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  always_comb begin
    q_stat.full  = fill_r == 2'd2;
    q_stat.empty = fill_r == 2'd0;
    pop_item     = slot_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/nss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nss_back
  import nss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CNT_W-1:0]   cfg_data,
  input  wire q_stat_t            q_stat,
  input  wire item_t              pop_item,
  output logic                    pop,
  output logic                    out_valid,
  output logic                    out_found,
  output logic [IDX_W-1:0]        out_nearest_index,
  output logic [DIST_W-1:0]       out_nearest_distance
);

  logic [ENT_W-1:0] mem [MAX_SEGMENTS];
  logic [ENT_W-1:0] rd_r;
  logic             mem_we;

  bk_state_t state_r, state_nxt;
  item_t     item_r;
  logic [CNT_W-1:0] seg_count_r, cnt_r, lim_r;
  logic             found_r;
  logic [IDX_W-1:0] best_i_r;
  logic [DIST_W-1:0] best_d_r;
  logic             out_valid_r, out_found_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r, wx_r, wy_r, wz_r, vx_r, vy_r, vz_r;
  logic [4:0]               step_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [SQ_W-1:0]          len2_r, a2_r, b2_r;
  logic signed [CRS_W-1:0]  cx_r, cy_r, cz_r;
  logic [NUM_W-1:0]         n_r;
  logic [5:0]               it_r;
  logic [SQ_W-1:0]          drem_r;
  logic [QUO_W-1:0]         num_r, quo_r, sx_r;
  logic [REM_W-1:0]         srem_r;
  logic [ROOT_W-1:0]        root_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [CRS_W-1:0]         mag_x, mag_y, mag_z;
  logic signed [MUL_W-1:0]  hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;
  logic [NUM_W-1:0]         t_n;
  logic [SQ_W:0]            drem_sh;
  logic                     d_ge;
  logic [REM_W-1:0]         srem_sh, trial;
  logic                     s_ge;
  logic                     inner;
  logic                     excl_hit;
  logic [DIST_W-1:0]        cur_dist;
  logic signed [COORD_W-1:0] s_x, s_y, s_z, q_x, q_y, q_z;

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_nearest_index    = out_idx_r;
  assign out_nearest_distance = out_dist_r;

  // split cross magnitudes into halves for the shared multiplier
  always_comb begin
    mag_x = cx_r[CRS_W-1] ? CRS_W'(-cx_r) : CRS_W'(cx_r);
    mag_y = cy_r[CRS_W-1] ? CRS_W'(-cy_r) : CRS_W'(cy_r);
    mag_z = cz_r[CRS_W-1] ? CRS_W'(-cz_r) : CRS_W'(cz_r);
    lo_x  = {1'b0, mag_x[LO_W-1:0]};
    hi_x  = {3'b000, mag_x[SQ_W-1:LO_W]};
    lo_y  = {1'b0, mag_y[LO_W-1:0]};
    hi_y  = {3'b000, mag_y[SQ_W-1:LO_W]};
    lo_z  = {1'b0, mag_z[LO_W-1:0]};
    hi_z  = {3'b000, mag_z[SQ_W-1:LO_W]};
  end

  always_comb begin
    case (step_r)
      5'd0:    begin mul_a = MUL_W'(wx_r); mul_b = MUL_W'(dx_r); end
      5'd1:    begin mul_a = MUL_W'(wy_r); mul_b = MUL_W'(dy_r); end
      5'd2:    begin mul_a = MUL_W'(wz_r); mul_b = MUL_W'(dz_r); end
      5'd3:    begin mul_a = MUL_W'(dx_r); mul_b = MUL_W'(dx_r); end
      5'd4:    begin mul_a = MUL_W'(dy_r); mul_b = MUL_W'(dy_r); end
      5'd5:    begin mul_a = MUL_W'(dz_r); mul_b = MUL_W'(dz_r); end
      5'd6:    begin mul_a = MUL_W'(wx_r); mul_b = MUL_W'(wx_r); end
      5'd7:    begin mul_a = MUL_W'(wy_r); mul_b = MUL_W'(wy_r); end
      5'd8:    begin mul_a = MUL_W'(wz_r); mul_b = MUL_W'(wz_r); end
      5'd9:    begin mul_a = MUL_W'(vx_r); mul_b = MUL_W'(vx_r); end
      5'd10:   begin mul_a = MUL_W'(vy_r); mul_b = MUL_W'(vy_r); end
      5'd11:   begin mul_a = MUL_W'(vz_r); mul_b = MUL_W'(vz_r); end
      5'd12:   begin mul_a = MUL_W'(wy_r); mul_b = MUL_W'(dz_r); end
      5'd13:   begin mul_a = MUL_W'(wz_r); mul_b = MUL_W'(dy_r); end
      5'd14:   begin mul_a = MUL_W'(wz_r); mul_b = MUL_W'(dx_r); end
      5'd15:   begin mul_a = MUL_W'(wx_r); mul_b = MUL_W'(dz_r); end
      5'd16:   begin mul_a = MUL_W'(wx_r); mul_b = MUL_W'(dy_r); end
      5'd17:   begin mul_a = MUL_W'(wy_r); mul_b = MUL_W'(dx_r); end
      5'd18:   begin mul_a = hi_x; mul_b = hi_x; end
      5'd19:   begin mul_a = hi_x; mul_b = lo_x; end
      5'd20:   begin mul_a = lo_x; mul_b = lo_x; end
      5'd21:   begin mul_a = hi_y; mul_b = hi_y; end
      5'd22:   begin mul_a = hi_y; mul_b = lo_y; end
      5'd23:   begin mul_a = lo_y; mul_b = lo_y; end
      5'd24:   begin mul_a = hi_z; mul_b = hi_z; end
      5'd25:   begin mul_a = hi_z; mul_b = lo_z; end
      5'd26:   begin mul_a = lo_z; mul_b = lo_z; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    t_n      = NUM_W'(prod_r[PROD_W-2:0]);
    drem_sh  = {drem_r, num_r[QUO_W-1]};
    d_ge     = drem_sh >= {1'b0, len2_r};
    srem_sh  = {srem_r[REM_W-3:0], sx_r[QUO_W-1:QUO_W-2]};
    trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
    s_ge     = srem_sh >= trial;
    inner    = (len2_r != '0) && (dot_r > 0) && (dot_r < $signed({1'b0, len2_r}));
    excl_hit = item_r.excl_en && (item_r.excl_idx == cnt_r[IDX_W-1:0]);
    cur_dist = root_r[ROOT_W-1] ? DIST_MAX : root_r[DIST_W-1:0];
    s_x      = rd_r[6*COORD_W-1:5*COORD_W];
    s_y      = rd_r[5*COORD_W-1:4*COORD_W];
    s_z      = rd_r[4*COORD_W-1:3*COORD_W];
    q_x      = rd_r[3*COORD_W-1:2*COORD_W];
    q_y      = rd_r[2*COORD_W-1:COORD_W];
    q_z      = rd_r[COORD_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (pop_item.op == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            state_nxt = BK_NEXT;
          end
        end
      end
      BK_NEXT: begin
        if (cnt_r >= lim_r) begin
          state_nxt = BK_DONE;
        end else if (!excl_hit) begin
          state_nxt = BK_FETCH;
        end
      end
      BK_FETCH: state_nxt = BK_LOAD;
      BK_LOAD:  state_nxt = BK_MUL;
      BK_MUL:   state_nxt = BK_ACC;
      BK_ACC: begin
        state_nxt = (step_r == 5'(MUL_STEPS - 1)) ? BK_DEC : BK_MUL;
      end
      BK_DEC:  state_nxt = inner ? BK_DIV : BK_SQRT;
      BK_DIV: begin
        if (it_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (it_r == 6'(SQRT_STEPS - 1)) begin
          state_nxt = BK_CMP;
        end
      end
      BK_CMP:  state_nxt = BK_NEXT;
      BK_DONE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      seg_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == BK_DONE;
      if (cfg_we) begin
        seg_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pop_item.seg_index] <= {pop_item.p_x, pop_item.p_y, pop_item.p_z,
                                  pop_item.e_x, pop_item.e_y, pop_item.e_z};
    end
    rd_r <= mem[cnt_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        item_r  <= pop_item;
        cnt_r   <= '0;
        found_r <= 1'b0;
        lim_r   <= (32'(seg_count_r) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : seg_count_r;
      end
      BK_NEXT: begin
        if (excl_hit && cnt_r < lim_r) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      BK_LOAD: begin
        dx_r   <= DIFF_W'(q_x) - DIFF_W'(s_x);
        dy_r   <= DIFF_W'(q_y) - DIFF_W'(s_y);
        dz_r   <= DIFF_W'(q_z) - DIFF_W'(s_z);
        wx_r   <= DIFF_W'(item_r.p_x) - DIFF_W'(s_x);
        wy_r   <= DIFF_W'(item_r.p_y) - DIFF_W'(s_y);
        wz_r   <= DIFF_W'(item_r.p_z) - DIFF_W'(s_z);
        vx_r   <= DIFF_W'(item_r.p_x) - DIFF_W'(q_x);
        vy_r   <= DIFF_W'(item_r.p_y) - DIFF_W'(q_y);
        vz_r   <= DIFF_W'(item_r.p_z) - DIFF_W'(q_z);
        step_r <= '0;
      end
      BK_MUL: prod_r <= mul_a * mul_b;
      BK_ACC: begin
        step_r <= step_r + 1'b1;
        case (step_r)
          5'd0:    dot_r  <= prod_r[DOT_W-1:0];
          5'd1:    dot_r  <= dot_r + $signed(prod_r[DOT_W-1:0]);
          5'd2:    dot_r  <= dot_r + $signed(prod_r[DOT_W-1:0]);
          5'd3:    len2_r <= prod_r[SQ_W-1:0];
          5'd4:    len2_r <= len2_r + prod_r[SQ_W-1:0];
          5'd5:    len2_r <= len2_r + prod_r[SQ_W-1:0];
          5'd6:    a2_r   <= prod_r[SQ_W-1:0];
          5'd7:    a2_r   <= a2_r + prod_r[SQ_W-1:0];
          5'd8:    a2_r   <= a2_r + prod_r[SQ_W-1:0];
          5'd9:    b2_r   <= prod_r[SQ_W-1:0];
          5'd10:   b2_r   <= b2_r + prod_r[SQ_W-1:0];
          5'd11:   b2_r   <= b2_r + prod_r[SQ_W-1:0];
          5'd12:   cx_r   <= prod_r[CRS_W-1:0];
          5'd13:   cx_r   <= cx_r - $signed(prod_r[CRS_W-1:0]);
          5'd14:   cy_r   <= prod_r[CRS_W-1:0];
          5'd15:   cy_r   <= cy_r - $signed(prod_r[CRS_W-1:0]);
          5'd16:   cz_r   <= prod_r[CRS_W-1:0];
          5'd17:   cz_r   <= cz_r - $signed(prod_r[CRS_W-1:0]);
          5'd18:   n_r    <= t_n << (2 * LO_W);
          5'd19:   n_r    <= n_r + (t_n << (LO_W + 1));
          5'd20:   n_r    <= n_r + t_n;
          5'd21:   n_r    <= n_r + (t_n << (2 * LO_W));
          5'd22:   n_r    <= n_r + (t_n << (LO_W + 1));
          5'd23:   n_r    <= n_r + t_n;
          5'd24:   n_r    <= n_r + (t_n << (2 * LO_W));
          5'd25:   n_r    <= n_r + (t_n << (LO_W + 1));
          5'd26:   n_r    <= n_r + t_n;
          default: n_r    <= n_r;
        endcase
      end
      BK_DEC: begin
        it_r   <= '0;
        drem_r <= n_r[NUM_W-1:QUO_W];
        num_r  <= n_r[QUO_W-1:0];
        srem_r <= '0;
        root_r <= '0;
        sx_r   <= (a2_r < b2_r) ? QUO_W'(a2_r) : QUO_W'(b2_r);
      end
      BK_DIV: begin
        num_r  <= num_r << 1;
        quo_r  <= {quo_r[QUO_W-2:0], d_ge};
        drem_r <= d_ge ? SQ_W'(drem_sh - {1'b0, len2_r}) : drem_sh[SQ_W-1:0];
        if (it_r == 6'(DIV_STEPS - 1)) begin
          it_r <= '0;
          sx_r <= {quo_r[QUO_W-2:0], d_ge};
        end else begin
          it_r <= it_r + 1'b1;
        end
      end
      BK_SQRT: begin
        it_r   <= it_r + 1'b1;
        sx_r   <= sx_r << 2;
        srem_r <= s_ge ? (srem_sh - trial) : srem_sh;
        root_r <= {root_r[ROOT_W-2:0], s_ge};
      end
      BK_CMP: begin
        cnt_r <= cnt_r + 1'b1;
        if (cur_dist < item_r.radius && (!found_r || cur_dist < best_d_r)) begin
          found_r  <= 1'b1;
          best_i_r <= cnt_r[IDX_W-1:0];
          best_d_r <= cur_dist;
        end
      end
      BK_DONE: begin
        out_found_r <= found_r;
        out_idx_r   <= found_r ? best_i_r : '0;
        out_dist_r  <= found_r ? best_d_r : '0;
      end
      default: begin
        it_r <= it_r;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/nearest_segment_search.sv =====
// segment write: queued at start, written to the table when popped; no result
// search: excluded segments are skipped; others run the shared multiplier sequence,
// the 36-step divider when the projection is interior, then the 18-step root
// a two-word command queue lets start be taken while a search runs; busy when it is full
// result strobe out_valid lasts one cycle; the receiver cannot stall
// synchronous active-low reset clears control and segment_count; table is undefined
`timescale 1ns / 1ps
`default_nettype none
module nearest_segment_search
  import nss_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_cmd,
  input  wire logic [IDX_W-1:0]           in_seg_index,
  input  wire logic signed [COORD_W-1:0]  in_p_x,
  input  wire logic signed [COORD_W-1:0]  in_p_y,
  input  wire logic signed [COORD_W-1:0]  in_p_z,
  input  wire logic signed [COORD_W-1:0]  in_e_x,
  input  wire logic signed [COORD_W-1:0]  in_e_y,
  input  wire logic signed [COORD_W-1:0]  in_e_z,
  input  wire logic signed [CNT_W-1:0]    in_exclude_index,
  input  wire logic [RAD_W-1:0]           in_scan_radius,
  input  wire logic                       cfg_we,
  input  wire logic [CNT_W-1:0]           cfg_data,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [IDX_W-1:0]                out_nearest_index,
  output logic [DIST_W-1:0]               out_nearest_distance
);

  q_stat_t q_stat;
  logic    push, pop;
  item_t   push_item, pop_item;

  nss_front u_front (
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_seg_index     (in_seg_index),
    .in_p_x           (in_p_x),
    .in_p_y           (in_p_y),
    .in_p_z           (in_p_z),
    .in_e_x           (in_e_x),
    .in_e_y           (in_e_y),
    .in_e_z           (in_e_z),
    .in_exclude_index (in_exclude_index),
    .in_scan_radius   (in_scan_radius),
    .q_stat           (q_stat),
    .push             (push),
    .push_item        (push_item)
  );

  nss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  nss_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .q_stat               (q_stat),
    .pop_item             (pop_item),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_found            (out_found),
    .out_nearest_index    (out_nearest_index),
    .out_nearest_distance (out_nearest_distance)
  );

endmodule
`default_nettype wire

// ===== design/nss_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_segment_search_assert.svh"
module nss_checker
  import nss_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_found,
  input wire logic [IDX_W-1:0]  out_nearest_index,
  input wire logic [DIST_W-1:0] out_nearest_distance
);

  `NSS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `NSS_ASSERT_IMPLY(a_miss_zero, out_valid && !out_found, out_nearest_index == '0 && out_nearest_distance == '0)
  `NSS_ASSERT_IMPLY(a_hit_below_max, out_valid && out_found, out_nearest_distance != DIST_MAX)
  `NSS_ASSERT_IMPLY(a_quiet_after_reset, $past(!rst_n), !out_valid)

endmodule

bind nearest_segment_search nss_checker u_nss_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_found            (out_found),
  .out_nearest_index    (out_nearest_index),
  .out_nearest_distance (out_nearest_distance)
);
`default_nettype wire
